// ----- rtl/core/arl_pkg.sv -----
`timescale 1ns / 1ps

package arl_pkg;

  localparam logic [1:0] OP_STORE    = 2'd0;
  localparam logic [1:0] OP_GENERATE = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  localparam int          LETTER_W    = 7;
  localparam int          DIGIT_W     = 5;
  localparam logic [4:0]  LAST_DIGIT  = 5'd25;
  localparam logic [6:0]  LETTER_BASE = 7'd65;
  localparam int          OUT_W       = 24;

  typedef struct packed {
    logic [LETTER_W-1:0] label_second;
    logic [LETTER_W-1:0] label_first;
    logic                label_valid;
    logic                present;
    logic                status;
  } arl_res_t;

endpackage

// ----- rtl/core/arl_ram.sv -----
`timescale 1ns / 1ps

module arl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/arl_seq.sv -----
`timescale 1ns / 1ps

module arl_seq #(
  parameter int TABLE_DEPTH  = 128,
  parameter int ADDRESS_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     in_op_i,
  input  logic [ADDRESS_BITS-1:0]        in_addr_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output arl_pkg::arl_res_t              res_o,
  output logic                           mem_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr_o,
  output logic [ADDRESS_BITS-1:0]        mem_wdata_o,
  output logic                           mem_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr_o,
  input  logic [ADDRESS_BITS-1:0]        mem_rdata_i
);
  import arl_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PSTART = 3'd2;
  localparam logic [2:0] S_PLOAD  = 3'd3;
  localparam logic [2:0] S_PSTEP  = 3'd4;
  localparam logic [2:0] S_PEND   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        lab_q, lab_d;
  logic [CNT_W-1:0]        k_q, k_d;
  logic [DIGIT_W-1:0]      kq_q, kq_d, kr_q, kr_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        pslot_q, pslot_d;
  logic [DIGIT_W-1:0]      pq_q, pq_d, pr_q, pr_d;
  logic [IDX_W-1:0]        lim_q, lim_d;
  logic [IDX_W-1:0]        sk_q, sk_d;
  logic [ADDRESS_BITS-1:0] cur_q, cur_d;
  logic [1:0]              op_q, op_d;
  logic [ADDRESS_BITS-1:0] addr_q, addr_d;
  arl_res_t                res_q, res_d;
  logic                    full;
  logic                    more_steps;

  assign full       = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign more_steps = ({1'b0, sk_q} + 1'b1) < {1'b0, lim_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      lab_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lab_q   <= lab_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    kq_q    <= kq_d;
    kr_q    <= kr_d;
    pslot_q <= pslot_d;
    pq_q    <= pq_d;
    pr_q    <= pr_d;
    lim_q   <= lim_d;
    sk_q    <= sk_d;
    cur_q   <= cur_d;
    op_q    <= op_d;
    addr_q  <= addr_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lab_d       = lab_q;
    k_d         = k_q;
    kq_d        = kq_q;
    kr_d        = kr_q;
    pend_d      = pend_q;
    pslot_d     = pslot_q;
    pq_d        = pq_q;
    pr_d        = pr_q;
    lim_d       = lim_q;
    sk_d        = sk_q;
    cur_d       = cur_q;
    op_d        = op_q;
    addr_d      = addr_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = cur_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_op_i;
          addr_d = in_addr_i;
          res_d  = '0;
          k_d    = '0;
          kq_d   = '0;
          kr_d   = '0;
          pend_d = 1'b0;
          case (in_op_i)
            OP_STORE, OP_QUERY: state_d = S_SCAN;
            OP_GENERATE: begin
              if (cnt_q < CNT_W'(2)) begin
                lab_d   = cnt_q;
                state_d = S_EMIT;
              end else begin
                lim_d   = IDX_W'(cnt_q - 1'b1);
                state_d = S_PSTART;
              end
            end
            default: state_d = S_EMIT;
          endcase
        end
      end

      // one read issued per cycle, its data compared in the next cycle
      S_SCAN: begin
        if (pend_q && (mem_rdata_i == addr_q)) begin
          pend_d       = 1'b0;
          res_d.present = 1'b1;
          if ((op_q == OP_QUERY) && (CNT_W'(pslot_q) < lab_q)) begin
            res_d.label_valid  = 1'b1;
            res_d.label_first  = LETTER_BASE + LETTER_W'(pq_q);
            res_d.label_second = LETTER_BASE + LETTER_W'(pr_q);
          end
          state_d = S_EMIT;
        end else if (k_q < cnt_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = k_q[IDX_W-1:0];
          pend_d      = 1'b1;
          pslot_d     = k_q[IDX_W-1:0];
          pq_d        = kq_q;
          pr_d        = kr_q;
          k_d         = k_q + 1'b1;
          if (kr_q == LAST_DIGIT) begin
            kr_d = '0;
            kq_d = kq_q + 1'b1;
          end else begin
            kr_d = kr_q + 1'b1;
          end
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (op_q == OP_STORE) begin
              if (full) begin
                res_d.status = 1'b1;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_q[IDX_W-1:0];
                mem_wdata_o = addr_q;
                cnt_d       = cnt_q + 1'b1;
              end
            end
            state_d = S_EMIT;
          end
        end
      end

      // bubble pass: cur_q carries the running maximum
      S_PSTART: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = '0;
        state_d     = S_PLOAD;
      end

      S_PLOAD: begin
        cur_d       = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = IDX_W'(1);
        sk_d        = '0;
        state_d     = S_PSTEP;
      end

      S_PSTEP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sk_q;
        if (cur_q > mem_rdata_i) begin
          mem_wdata_o = mem_rdata_i;
        end else begin
          mem_wdata_o = cur_q;
          cur_d       = mem_rdata_i;
        end
        if (more_steps) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = sk_q + IDX_W'(2);
          sk_d        = sk_q + 1'b1;
        end else begin
          state_d = S_PEND;
        end
      end

      S_PEND: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lim_q;
        mem_wdata_o = cur_q;
        if (lim_q == IDX_W'(1)) begin
          lab_d   = cnt_q;
          state_d = S_EMIT;
        end else begin
          lim_d   = lim_q - 1'b1;
          state_d = S_PSTART;
        end
      end

      S_EMIT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

endmodule

// ----- rtl/core/address_rank_labeller.sv -----
`timescale 1ns / 1ps

// channel  | dir | tdata                                   | tuser
// s_axis   | in  | address                                 | opcode
// m_axis   | out | status, present, label_valid,           | -
//          |     | label_first[6:0], label_second[6:0]     |
//
// Store and query: the n entries held are scanned through the single RAM read port,
// and a hit ends the scan early.
// Generate: bubble-sorts the table in place for n >= 2, one RAM write per bubble compare.
// Reset clears the entry and label counts; the RAM is not cleared.
// One result register: a new item is accepted while a result waits on m_axis.

module address_rank_labeller #(
  parameter int TABLE_DEPTH  = 128,
  parameter int ADDRESS_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((ADDRESS_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // address
  input  logic [1:0]                             s_axis_tuser,  // opcode
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // status, present, label_valid, label_first[6:0], label_second[6:0], zero pad
  output logic [arl_pkg::OUT_W-1:0]              m_axis_tdata
);
  import arl_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic                    res_valid, res_ready;
  arl_res_t                res;
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;
  logic [ADDRESS_BITS-1:0] mem_wdata, mem_rdata;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_W-1:0]        m_data_q, m_data_d;

  arl_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_addr_i  (s_axis_tdata[ADDRESS_BITS-1:0]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  arl_ram #(
    .WIDTH(ADDRESS_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_addr_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
      m_data_d  = OUT_W'(res);
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- rtl/core/arl_checker.sv -----
`timescale 1ns / 1ps

module arl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [arl_pkg::OUT_W-1:0] m_axis_tdata
);
  import arl_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed under stall");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while busy");

  // status never comes with a hit, and a label only with a hit
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((!m_axis_tdata[0] || !m_axis_tdata[1]) &&
                       (!m_axis_tdata[2] || m_axis_tdata[1])))
    else $error("inconsistent status flags");

  // letters are A..Z with a label and zero without
  a_letters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2] ?
      (m_axis_tdata[9:3] >= LETTER_BASE && m_axis_tdata[9:3] <= LETTER_BASE + 7'd25 &&
       m_axis_tdata[16:10] >= LETTER_BASE && m_axis_tdata[16:10] <= LETTER_BASE + 7'd25) :
      (m_axis_tdata[16:3] == 14'd0)))
    else $error("bad label letters");

endmodule

bind address_rank_labeller arl_checker u_arl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
